// ----- src/obot_pkg.sv -----
// Package for the oriented box overlap test unit.
// Field widths, configuration register indexes and the pipeline control type.
// No dependencies.
package obot_pkg;

   localparam int DEF_TRIG_FRAC_BITS = 15;

   localparam int COORD_W   = 28;
   localparam int HALF_W    = 20;
   localparam int MARGIN_W  = 16;
   localparam int DELTA_W   = COORD_W + 1;
   localparam int EXT_HALF_W = HALF_W + 1;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 28;

   localparam logic [CSR_IDX_W-1:0] CSR_REF_CENTER_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_REF_CENTER_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_REF_HALF_LEN = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_REF_HALF_WID = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_REF_COS      = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_REF_SIN      = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_LON_MARGIN   = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_LAT_MARGIN   = CSR_IDX_W'(7);

   localparam int NUM_STAGES = 5;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } stage_ctrl_type;

endpackage

// ----- src/oriented_box_overlap_test_unit.sv -----
// Top level of the oriented box overlap test unit: pipeline control and assembly.
// Depends on obot_pkg, obot_csr, obot_proj and obot_axis.
//
// Usage:
//   csr_*  : writes the reference box (centre, half sizes, heading cos/sin and
//            the two margins); csr_ready is always high. Write only while idle.
//   req_*  : one tested box per transaction, taken when req_valid is high and
//            req_stall is low.
//   rsp_*  : one overlap flag per request, in request order, taken when
//            rsp_valid is high and rsp_stall is low.
// A request passes to its response through five register
// stages: offset, products, projection sums, extent products, compare.
// Throughput is one transaction per cycle while the response side is free.
// A stalled response holds its stage; earlier stages keep advancing into
// empty slots, and req_stall rises only once all five stages are full.
// Reset clears the stage valid bits and loads the reference registers with a
// zero-size box at the origin heading along x.
module oriented_box_overlap_test_unit import obot_pkg::*; #(
   parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [COORD_W-1:0]      req_other_center_x,
   input  logic signed [COORD_W-1:0]      req_other_center_y,
   input  logic [HALF_W-1:0]              req_other_half_len,
   input  logic [HALF_W-1:0]              req_other_half_wid,
   input  logic signed [TRIG_FRAC_BITS:0] req_other_cos,
   input  logic signed [TRIG_FRAC_BITS:0] req_other_sin,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_overlaps
);

   localparam int PW = DELTA_W + TRIG_FRAC_BITS + 2;
   localparam int AW = 2 * TRIG_FRAC_BITS + 3;

   logic signed [COORD_W-1:0]        ref_center_x, ref_center_y;
   logic signed [TRIG_FRAC_BITS:0]   ref_cos, ref_sin;
   logic [EXT_HALF_W-1:0]            ref_half_len_ext, ref_half_wid_ext;
   logic [PW-1:0]                    proj_mag [4];
   logic [AW-1:0]                    dot_mag, crs_mag;
   logic [HALF_W-1:0]                half_len_s3, half_wid_s3;
   logic [NUM_STAGES-1:0]            valid_ff, valid_in;
   stage_ctrl_type                   ctrl;

   always_comb begin
      ctrl.en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ctrl.en[k] = !valid_ff[k] || ctrl.en[k+1];
      end
   end

   always_comb begin
      valid_in[0] = ctrl.en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = ctrl.en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ctrl.en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   obot_csr #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .ref_center_x     (ref_center_x),
      .ref_center_y     (ref_center_y),
      .ref_cos          (ref_cos),
      .ref_sin          (ref_sin),
      .ref_half_len_ext (ref_half_len_ext),
      .ref_half_wid_ext (ref_half_wid_ext)
   );

   obot_proj #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_proj (
      .clock          (clock),
      .ctrl           (ctrl),
      .other_center_x (req_other_center_x),
      .other_center_y (req_other_center_y),
      .other_half_len (req_other_half_len),
      .other_half_wid (req_other_half_wid),
      .other_cos      (req_other_cos),
      .other_sin      (req_other_sin),
      .ref_center_x   (ref_center_x),
      .ref_center_y   (ref_center_y),
      .ref_cos        (ref_cos),
      .ref_sin        (ref_sin),
      .proj_mag       (proj_mag),
      .dot_mag        (dot_mag),
      .crs_mag        (crs_mag),
      .half_len_out   (half_len_s3),
      .half_wid_out   (half_wid_s3)
   );

   obot_axis #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_axis (
      .clock            (clock),
      .ctrl             (ctrl),
      .proj_mag         (proj_mag),
      .dot_mag          (dot_mag),
      .crs_mag          (crs_mag),
      .other_half_len   (half_len_s3),
      .other_half_wid   (half_wid_s3),
      .ref_half_len_ext (ref_half_len_ext),
      .ref_half_wid_ext (ref_half_wid_ext),
      .overlaps         (rsp_overlaps)
   );

   a_accept_fills_first_stage: assert property (
      @(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0]
   ) else $error("accepted transaction not captured in first stage");

   a_stall_only_when_full: assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> &valid_ff
   ) else $error("request stalled with an empty pipeline slot");

   a_free_output_frees_input: assert property (
      @(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall
   ) else $error("request stalled while response side is free");

   a_response_from_last_stage: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !valid_ff[NUM_STAGES-2] |=> !rsp_valid
   ) else $error("response repeated after delivery");

endmodule

// ----- src/obot_csr.sv -----
// Configuration registers of the reference box, with the enlarged half sizes.
// Depends on obot_pkg.
module obot_csr import obot_pkg::*; #(
   parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   output logic signed [COORD_W-1:0]     ref_center_x,
   output logic signed [COORD_W-1:0]     ref_center_y,
   output logic signed [TRIG_FRAC_BITS:0] ref_cos,
   output logic signed [TRIG_FRAC_BITS:0] ref_sin,
   output logic [EXT_HALF_W-1:0]         ref_half_len_ext,
   output logic [EXT_HALF_W-1:0]         ref_half_wid_ext
);

   localparam int TW = TRIG_FRAC_BITS + 1;

   logic signed [COORD_W-1:0] center_x_ff, center_y_ff;
   logic [HALF_W-1:0]         half_len_ff, half_wid_ff;
   logic signed [TW-1:0]      cos_ff, sin_ff;
   logic [MARGIN_W-1:0]       lon_margin_ff, lat_margin_ff;
   logic                      wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         half_len_ff   <= '0;
         half_wid_ff   <= '0;
         cos_ff        <= {1'b0, {TRIG_FRAC_BITS{1'b1}}};
         sin_ff        <= '0;
         lon_margin_ff <= '0;
         lat_margin_ff <= '0;
      end else if (wr_en) begin
         case (csr_index)
            CSR_REF_CENTER_X: center_x_ff   <= csr_wdata[COORD_W-1:0];
            CSR_REF_CENTER_Y: center_y_ff   <= csr_wdata[COORD_W-1:0];
            CSR_REF_HALF_LEN: half_len_ff   <= csr_wdata[HALF_W-1:0];
            CSR_REF_HALF_WID: half_wid_ff   <= csr_wdata[HALF_W-1:0];
            CSR_REF_COS:      cos_ff        <= csr_wdata[TW-1:0];
            CSR_REF_SIN:      sin_ff        <= csr_wdata[TW-1:0];
            CSR_LON_MARGIN:   lon_margin_ff <= csr_wdata[MARGIN_W-1:0];
            CSR_LAT_MARGIN:   lat_margin_ff <= csr_wdata[MARGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign ref_center_x     = center_x_ff;
   assign ref_center_y     = center_y_ff;
   assign ref_cos          = cos_ff;
   assign ref_sin          = sin_ff;
   assign ref_half_len_ext = EXT_HALF_W'(half_len_ff) + EXT_HALF_W'(lon_margin_ff);
   assign ref_half_wid_ext = EXT_HALF_W'(half_wid_ff) + EXT_HALF_W'(lat_margin_ff);

endmodule

// ----- src/obot_proj.sv -----
// Stages one to three: centre offset, axis projections and heading agreement terms.
// Depends on obot_pkg.
module obot_proj import obot_pkg::*; #(
   parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
   input  logic                                clock,
   input  stage_ctrl_type                      ctrl,
   input  logic signed [COORD_W-1:0]           other_center_x,
   input  logic signed [COORD_W-1:0]           other_center_y,
   input  logic [HALF_W-1:0]                   other_half_len,
   input  logic [HALF_W-1:0]                   other_half_wid,
   input  logic signed [TRIG_FRAC_BITS:0]      other_cos,
   input  logic signed [TRIG_FRAC_BITS:0]      other_sin,
   input  logic signed [COORD_W-1:0]           ref_center_x,
   input  logic signed [COORD_W-1:0]           ref_center_y,
   input  logic signed [TRIG_FRAC_BITS:0]      ref_cos,
   input  logic signed [TRIG_FRAC_BITS:0]      ref_sin,
   output logic [DELTA_W+TRIG_FRAC_BITS+1:0]   proj_mag [4],
   output logic [2*TRIG_FRAC_BITS+2:0]         dot_mag,
   output logic [2*TRIG_FRAC_BITS+2:0]         crs_mag,
   output logic [HALF_W-1:0]                   half_len_out,
   output logic [HALF_W-1:0]                   half_wid_out
);

   localparam int TW = TRIG_FRAC_BITS + 1;
   localparam int MW = DELTA_W + TW;
   localparam int PW = MW + 1;
   localparam int QW = 2 * TW;
   localparam int AW = QW + 1;

   // stage one
   logic signed [DELTA_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [HALF_W-1:0]         hl1_ff, hw1_ff;
   logic signed [TW-1:0]      oc1_ff, os1_ff, rc1_ff, rs1_ff;

   // stage two
   logic signed [MW-1:0] pxc_ff, pys_ff, pxs_ff, pyc_ff;
   logic signed [MW-1:0] qxc_ff, qys_ff, qxs_ff, qyc_ff;
   logic signed [QW-1:0] rcoc_ff, rsos_ff, rsoc_ff, rcos_ff;
   logic [HALF_W-1:0]    hl2_ff, hw2_ff;

   // stage three
   logic signed [PW-1:0] proj_sum [4];
   logic signed [AW-1:0] dot_sum, crs_sum;
   logic [PW-1:0]        proj_mag_ff [4];
   logic [AW-1:0]        dot_mag_ff, crs_mag_ff;
   logic [HALF_W-1:0]    hl3_ff, hw3_ff;

   assign dx_in = DELTA_W'(other_center_x) - DELTA_W'(ref_center_x);
   assign dy_in = DELTA_W'(other_center_y) - DELTA_W'(ref_center_y);

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         hl1_ff <= other_half_len;
         hw1_ff <= other_half_wid;
         oc1_ff <= other_cos;
         os1_ff <= other_sin;
         rc1_ff <= ref_cos;
         rs1_ff <= ref_sin;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[1]) begin
         pxc_ff  <= dx_ff * rc1_ff;
         pys_ff  <= dy_ff * rs1_ff;
         pxs_ff  <= dx_ff * rs1_ff;
         pyc_ff  <= dy_ff * rc1_ff;
         qxc_ff  <= dx_ff * oc1_ff;
         qys_ff  <= dy_ff * os1_ff;
         qxs_ff  <= dx_ff * os1_ff;
         qyc_ff  <= dy_ff * oc1_ff;
         rcoc_ff <= rc1_ff * oc1_ff;
         rsos_ff <= rs1_ff * os1_ff;
         rsoc_ff <= rs1_ff * oc1_ff;
         rcos_ff <= rc1_ff * os1_ff;
         hl2_ff  <= hl1_ff;
         hw2_ff  <= hw1_ff;
      end
   end

   assign proj_sum[0] = PW'(pxc_ff) + PW'(pys_ff);
   assign proj_sum[1] = PW'(pxs_ff) - PW'(pyc_ff);
   assign proj_sum[2] = PW'(qxc_ff) + PW'(qys_ff);
   assign proj_sum[3] = PW'(qxs_ff) - PW'(qyc_ff);
   assign dot_sum     = AW'(rcoc_ff) + AW'(rsos_ff);
   assign crs_sum     = AW'(rsoc_ff) - AW'(rcos_ff);

   always_ff @(posedge clock) begin
      if (ctrl.en[2]) begin
         for (int k = 0; k < 4; k++) begin
            proj_mag_ff[k] <= proj_sum[k][PW-1] ? $unsigned(-proj_sum[k])
                                                : $unsigned(proj_sum[k]);
         end
         dot_mag_ff <= dot_sum[AW-1] ? $unsigned(-dot_sum) : $unsigned(dot_sum);
         crs_mag_ff <= crs_sum[AW-1] ? $unsigned(-crs_sum) : $unsigned(crs_sum);
         hl3_ff     <= hl2_ff;
         hw3_ff     <= hw2_ff;
      end
   end

   assign proj_mag     = proj_mag_ff;
   assign dot_mag      = dot_mag_ff;
   assign crs_mag      = crs_mag_ff;
   assign half_len_out = hl3_ff;
   assign half_wid_out = hw3_ff;

endmodule

// ----- src/obot_axis.sv -----
// Stages four and five: extent terms, per-axis comparison and the overlap decision.
// Depends on obot_pkg.
module obot_axis import obot_pkg::*; #(
   parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
   input  logic                               clock,
   input  stage_ctrl_type                     ctrl,
   input  logic [DELTA_W+TRIG_FRAC_BITS+1:0]  proj_mag [4],
   input  logic [2*TRIG_FRAC_BITS+2:0]        dot_mag,
   input  logic [2*TRIG_FRAC_BITS+2:0]        crs_mag,
   input  logic [HALF_W-1:0]                  other_half_len,
   input  logic [HALF_W-1:0]                  other_half_wid,
   input  logic [EXT_HALF_W-1:0]              ref_half_len_ext,
   input  logic [EXT_HALF_W-1:0]              ref_half_wid_ext,
   output logic                               overlaps
);

   localparam int T    = TRIG_FRAC_BITS;
   localparam int PW   = DELTA_W + T + 2;
   localparam int AW   = 2 * T + 3;
   localparam int TPW  = EXT_HALF_W + AW;
   localparam int SW   = TPW + 1;
   localparam int RW   = SW - T;
   localparam int HSW  = EXT_HALF_W + T;
   localparam int LW   = ((PW > HSW) ? PW : HSW) + 1;
   localparam int CMPW = ((LW > RW + 1) ? LW : RW + 1);

   logic [EXT_HALF_W-1:0] own_half [4];
   logic [EXT_HALF_W-1:0] hl_ext, hw_ext;
   logic signed [LW-1:0]  lhs_in [4];
   logic signed [LW-1:0]  lhs_ff [4];
   logic [TPW-1:0]        term_a_ff [4], term_b_ff [4];
   logic [SW-1:0]         term_sum [4];
   logic [RW-1:0]         rhs [4];
   logic [3:0]            axis_ok;
   logic                  overlap_ff;

   assign hl_ext      = EXT_HALF_W'(other_half_len);
   assign hw_ext      = EXT_HALF_W'(other_half_wid);
   assign own_half[0] = ref_half_len_ext;
   assign own_half[1] = ref_half_wid_ext;
   assign own_half[2] = hl_ext;
   assign own_half[3] = hw_ext;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         lhs_in[k] = $signed({{(LW-PW){1'b0}}, proj_mag[k]})
                   - $signed({{(LW-HSW){1'b0}}, own_half[k], {T{1'b0}}});
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[3]) begin
         lhs_ff       <= lhs_in;
         term_a_ff[0] <= hl_ext * dot_mag;
         term_b_ff[0] <= hw_ext * crs_mag;
         term_a_ff[1] <= hl_ext * crs_mag;
         term_b_ff[1] <= hw_ext * dot_mag;
         term_a_ff[2] <= ref_half_len_ext * dot_mag;
         term_b_ff[2] <= ref_half_wid_ext * crs_mag;
         term_a_ff[3] <= ref_half_len_ext * crs_mag;
         term_b_ff[3] <= ref_half_wid_ext * dot_mag;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         term_sum[k] = SW'(term_a_ff[k]) + SW'(term_b_ff[k]);
         rhs[k]      = term_sum[k][SW-1:T];
         axis_ok[k]  = CMPW'(lhs_ff[k]) <= $signed({{(CMPW-RW){1'b0}}, rhs[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[4]) begin
         overlap_ff <= &axis_ok;
      end
   end

   assign overlaps = overlap_ff;

endmodule
